// ===== rtl/ace_pkg.sv =====
// Shared types and constants of the arithmetic encoder core.
// Depends on nothing; ace_ctrl, ace_datapath and the top level import it.
package ace_pkg;

	// Coder precision, model count width and pending counter width.
	localparam int CODE_BITS    = 32;
	localparam int FREQ_BITS    = 16;
	localparam int PENDING_BITS = 8;

	// Input word layout and result buffer size.
	localparam int IN_FIELD_W   = 16;
	localparam int CUM_LOW_LSB  = 0;
	localparam int CUM_HIGH_LSB = 16;
	localparam int TOTAL_LSB    = 32;
	localparam int IN_DATA_W    = 48;
	localparam int BYTE_W       = 8;
	localparam int MAX_RESULTS  = 40;

	// Derived widths.
	localparam int RANGE_W    = CODE_BITS + 1;
	localparam int PROD_W     = RANGE_W + FREQ_BITS;
	localparam int DIV_STEPS  = PROD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);
	localparam int RES_AW     = $clog2(MAX_RESULTS);
	localparam int BITS_CNT_W = $clog2(BYTE_W);

	localparam logic [PENDING_BITS-1:0] PENDING_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_NARROW,
		S_RENORM,
		S_PEND,
		S_FIN_FIRST,
		S_FIN_PEND,
		S_FIN_LAST,
		S_PAD,
		S_OUT_RD,
		S_OUT_WR
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_DIV,
		OP_NARROW,
		OP_DECIDE,
		OP_MID,
		OP_PEND,
		OP_FIN_FIRST,
		OP_FIN_LAST,
		OP_PAD,
		OP_OUT_LOAD
	} op_t;

	// What one renormalization step has to do with the current interval.
	typedef enum logic [1:0] {
		R_ZERO,
		R_ONE,
		R_MID,
		R_DONE
	} rcode_t;

	typedef struct packed {
		op_t  op;
		logic clear;
	} cmd_t;

	typedef struct packed {
		rcode_t rcode;
		logic   fin;
		logic   bad;
		logic   pend_zero;
		logic   pend_one;
		logic   bits_seven;
		logic   have_bytes;
		logic   out_free;
		logic   out_last;
	} stat_t;

endpackage

// ===== rtl/arithmetic_encoder_core.sv =====
// Top level of the multi-symbol arithmetic encoder core.
// Depends on ace_pkg, ace_ctrl, ace_datapath (which holds ace_ram).
//
// Input s_*: an encode word (s_tuser low) carries a symbol's cumulative low and
// high counts and the model total; a finish word (s_tuser high) flushes the coder.
// Encode words with a zero total, a high count above the total or an empty
// symbol range are dropped without effect.
// Output m_*: one byte per word, first coded bit in bit 7. m_tlast marks the
// final byte of a request; m_tuser reports that the pending counter saturated
// (or the per-request byte buffer filled). A request may produce no byte.
// Order: an encode word is accepted and checked, runs through the bit-serial
// divider, is narrowed, renormalized with any pending bits released, and its
// bytes are read back from the result buffer. A finish word emits its first
// bit, the pending bits, its last bit and padding bits, then its bytes. One
// request is in work at a time; the next is accepted once the last byte sits
// in the output register, or once the work ends for a request with no byte. A
// stalled receiver holds up byte playout and so the input. Reset (arst_n low)
// restores the full interval and clears all pending, packing and flag state;
// a finish request leaves the coder in that same state.
module arithmetic_encoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata fields from bit 0 up: cum_low[15:0], cum_high[15:0], total_count[15:0]
	input  logic [ace_pkg::IN_DATA_W-1:0] s_tdata,
	// s_tuser fields from bit 0 up: action
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// m_tdata fields from bit 0 up: out_byte[7:0]
	output logic [ace_pkg::BYTE_W-1:0]    m_tdata,
	output logic                          m_tlast,
	// m_tuser fields from bit 0 up: pending_overflow
	output logic                          m_tuser
);
	import ace_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ace_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ace_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

// ===== rtl/ace_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ace_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ace_ctrl.sv =====
// Arithmetic encoder sequencer: walks each encode word through check, divide,
// narrow, renormalize and byte playout. Depends on ace_pkg.
module ace_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  ace_pkg::stat_t stat,
	output ace_pkg::cmd_t  cmd
);
	import ace_pkg::*;

	state_t               state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			div_cnt_q <= div_cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_cnt_d = div_cnt_q;
		cmd.op    = OP_NONE;
		cmd.clear = 1'b0;
		s_tready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.fin) begin
					state_d = S_FIN_FIRST;
				end else if (stat.bad) begin
					state_d = S_IDLE;
				end else begin
					cmd.op    = OP_MUL;
					div_cnt_d = '0;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op    = OP_DIV;
				div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_NARROW;
				end
			end
			S_NARROW: begin
				cmd.op  = OP_NARROW;
				state_d = S_RENORM;
			end
			S_RENORM: begin
				case (stat.rcode)
					R_ZERO, R_ONE: begin
						cmd.op = OP_DECIDE;
						if (!stat.pend_zero) begin
							state_d = S_PEND;
						end
					end
					R_MID: begin
						cmd.op = OP_MID;
					end
					default: begin
						state_d = stat.have_bytes ? S_OUT_RD : S_IDLE;
					end
				endcase
			end
			S_PEND: begin
				cmd.op = OP_PEND;
				if (stat.pend_one) begin
					state_d = S_RENORM;
				end
			end
			S_FIN_FIRST: begin
				cmd.op  = OP_FIN_FIRST;
				state_d = stat.pend_zero ? S_FIN_LAST : S_FIN_PEND;
			end
			S_FIN_PEND: begin
				cmd.op = OP_PEND;
				if (stat.pend_one) begin
					state_d = S_FIN_LAST;
				end
			end
			S_FIN_LAST: begin
				cmd.op  = OP_FIN_LAST;
				state_d = stat.bits_seven ? S_OUT_RD : S_PAD;
			end
			S_PAD: begin
				cmd.op = OP_PAD;
				if (stat.bits_seven) begin
					state_d = S_OUT_RD;
				end
			end
			S_OUT_RD: begin
				// The buffer read issued here lands in the next cycle.
				state_d = S_OUT_WR;
			end
			S_OUT_WR: begin
				if (stat.out_free) begin
					cmd.op = OP_OUT_LOAD;
					if (stat.out_last) begin
						cmd.clear = stat.fin;
						state_d   = S_IDLE;
					end else begin
						state_d = S_OUT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/ace_datapath.sv =====
// Datapath of the arithmetic encoder: interval registers, product and divider,
// bit packer, result buffer and output register. Depends on ace_pkg, ace_ram.
module ace_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ace_pkg::cmd_t                      cmd,
	output ace_pkg::stat_t                     stat,
	input  logic [ace_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ace_pkg::BYTE_W-1:0]         m_tdata,
	output logic                               m_tlast,
	output logic                               m_tuser
);
	import ace_pkg::*;

	typedef struct packed {
		logic [PROD_W-1:0]    acc;
		logic [FREQ_BITS-1:0] rem;
	} div_t;

	// One restoring division step: the dividend shifts out at the top while
	// quotient bits shift in at the bottom of the same register.
	function automatic div_t div_step(div_t cur, logic [FREQ_BITS-1:0] den);
		logic [FREQ_BITS:0] trial;
		logic [FREQ_BITS:0] diff;
		logic               ge;
		div_t               nxt;
		trial   = {cur.rem, cur.acc[PROD_W-1]};
		diff    = trial - {1'b0, den};
		ge      = trial >= {1'b0, den};
		nxt.rem = ge ? diff[FREQ_BITS-1:0] : trial[FREQ_BITS-1:0];
		nxt.acc = {cur.acc[PROD_W-2:0], ge};
		return nxt;
	endfunction

	// Coder state.
	logic [CODE_BITS-1:0]    low_q, high_q;
	logic [PENDING_BITS-1:0] pending_q;
	logic [BYTE_W-2:0]       shift_q;
	logic [BITS_CNT_W-1:0]   bits_q;
	logic                    overflow_q;
	logic                    emit_bit_q;

	// Word being worked on.
	logic                    fin_q;
	logic [FREQ_BITS-1:0]    cl_q, ch_q, tot_q;
	div_t                    divh_q, divl_q;

	// Result buffer bookkeeping and output register.
	logic [RES_CNT_W-1:0]    cnt_q, rd_idx_q;
	logic                    out_valid_q;
	logic [BYTE_W-1:0]       out_byte_q;
	logic                    out_last_q, out_ovf_q;

	logic [RANGE_W-1:0]      range_w, sum_h, sum_l;
	rcode_t                  rcode;
	logic                    first_bit;
	logic                    pb_en, pb_bit, byte_done, room, ram_we, ovf_set;
	logic [BYTE_W-1:0]       ram_wdata, ram_rdata;
	div_t                    divh_n, divl_n;

	assign range_w = RANGE_W'({1'b0, high_q}) - RANGE_W'({1'b0, low_q}) + RANGE_W'(1);
	assign sum_h   = RANGE_W'({1'b0, low_q}) + divh_q.acc[RANGE_W-1:0] - RANGE_W'(1);
	assign sum_l   = RANGE_W'({1'b0, low_q}) + divl_q.acc[RANGE_W-1:0];
	assign divh_n  = div_step(divh_q, tot_q);
	assign divl_n  = div_step(divl_q, tot_q);

	assign first_bit = low_q[CODE_BITS-1] | low_q[CODE_BITS-2];

	always_comb begin
		if (!high_q[CODE_BITS-1]) begin
			rcode = R_ZERO;
		end else if (low_q[CODE_BITS-1]) begin
			rcode = R_ONE;
		end else if (low_q[CODE_BITS-2] && !high_q[CODE_BITS-2]) begin
			rcode = R_MID;
		end else begin
			rcode = R_DONE;
		end
	end

	always_comb begin
		pb_en  = 1'b0;
		pb_bit = 1'b0;
		case (cmd.op)
			OP_DECIDE: begin
				pb_en  = 1'b1;
				pb_bit = (rcode == R_ONE);
			end
			OP_PEND, OP_FIN_LAST: begin
				pb_en  = 1'b1;
				pb_bit = ~emit_bit_q;
			end
			OP_FIN_FIRST: begin
				pb_en  = 1'b1;
				pb_bit = first_bit;
			end
			OP_PAD: begin
				pb_en = 1'b1;
			end
			default: begin
				pb_en  = 1'b0;
				pb_bit = 1'b0;
			end
		endcase
	end

	assign byte_done = pb_en && (bits_q == BITS_CNT_W'(BYTE_W - 1));
	assign room      = cnt_q < RES_CNT_W'(MAX_RESULTS);
	assign ram_we    = byte_done && room;
	assign ram_wdata = {shift_q, pb_bit};
	assign ovf_set   = (byte_done && !room) ||
		((cmd.op == OP_MID) && (pending_q == PENDING_MAX));

	ace_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_RESULTS)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[RES_AW-1:0]),
		.wdata(ram_wdata),
		.raddr(rd_idx_q[RES_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			high_q      <= '1;
			pending_q   <= '0;
			shift_q     <= '0;
			bits_q      <= '0;
			overflow_q  <= 1'b0;
			emit_bit_q  <= 1'b0;
			fin_q       <= 1'b0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pb_en) begin
				shift_q <= byte_done ? '0 : {shift_q[BYTE_W-3:0], pb_bit};
				bits_q  <= bits_q + BITS_CNT_W'(1);
			end
			if (ram_we) begin
				cnt_q <= cnt_q + RES_CNT_W'(1);
			end
			if (ovf_set) begin
				overflow_q <= 1'b1;
			end
			if (out_valid_q && m_tready && (cmd.op != OP_OUT_LOAD)) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					fin_q    <= s_tuser;
					cnt_q    <= '0;
					rd_idx_q <= '0;
				end
				OP_NARROW: begin
					high_q <= sum_h[CODE_BITS-1:0];
					low_q  <= sum_l[CODE_BITS-1:0];
				end
				OP_DECIDE: begin
					emit_bit_q <= (rcode == R_ONE);
					low_q      <= {low_q[CODE_BITS-2:0], 1'b0};
					high_q     <= {high_q[CODE_BITS-2:0], 1'b1};
				end
				OP_MID: begin
					if (pending_q != PENDING_MAX) begin
						pending_q <= pending_q + PENDING_BITS'(1);
					end
					// Subtracting a quarter and doubling fixes the top bits.
					low_q  <= {1'b0, low_q[CODE_BITS-3:0], 1'b0};
					high_q <= {1'b1, high_q[CODE_BITS-3:0], 1'b1};
				end
				OP_PEND: begin
					pending_q <= pending_q - PENDING_BITS'(1);
				end
				OP_FIN_FIRST: begin
					emit_bit_q <= first_bit;
				end
				OP_OUT_LOAD: begin
					out_valid_q <= 1'b1;
					rd_idx_q    <= rd_idx_q + RES_CNT_W'(1);
				end
				default: begin
				end
			endcase
			if (cmd.clear) begin
				low_q      <= '0;
				high_q     <= '1;
				pending_q  <= '0;
				shift_q    <= '0;
				bits_q     <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	// Payload registers: word fields, divider and output byte.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cl_q  <= s_tdata[CUM_LOW_LSB +: FREQ_BITS];
				ch_q  <= s_tdata[CUM_HIGH_LSB +: FREQ_BITS];
				tot_q <= s_tdata[TOTAL_LSB +: FREQ_BITS];
			end
			OP_MUL: begin
				divh_q.acc <= PROD_W'(range_w) * PROD_W'(ch_q);
				divl_q.acc <= PROD_W'(range_w) * PROD_W'(cl_q);
				divh_q.rem <= '0;
				divl_q.rem <= '0;
			end
			OP_DIV: begin
				divh_q <= divh_n;
				divl_q <= divl_n;
			end
			OP_OUT_LOAD: begin
				out_byte_q <= ram_rdata;
				out_last_q <= stat.out_last;
				out_ovf_q  <= overflow_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.rcode      = rcode;
	assign stat.fin        = fin_q;
	assign stat.bad        = (tot_q == '0) || (ch_q > tot_q) || (cl_q >= ch_q);
	assign stat.pend_zero  = (pending_q == '0);
	assign stat.pend_one   = (pending_q == PENDING_BITS'(1));
	assign stat.bits_seven = (bits_q == BITS_CNT_W'(BYTE_W - 1));
	assign stat.have_bytes = (cnt_q != '0);
	assign stat.out_free   = !out_valid_q || m_tready;
	assign stat.out_last   = (rd_idx_q == cnt_q - RES_CNT_W'(1));

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule
